/* rtl/core/fsp_pkg.sv */
// ---------------------------------------------------------------------------
// fsp_pkg
// Shared constants, types and helpers for the fixed slot pool allocator.
// ---------------------------------------------------------------------------
package fsp_pkg;

    localparam int BLOCK_BYTES = 4096;
    localparam int NUM_BLOCKS  = 8;
    localparam int FREE_DEPTH  = 4096;

    localparam int ADDR_W    = 32;
    localparam int SLOT_W    = 11;
    localparam int BLK_W     = 4;
    localparam int CNT_W     = $clog2(FREE_DEPTH + 1);
    localparam int IDX_W     = $clog2(FREE_DEPTH);
    localparam int STEP_W    = $clog2(ADDR_W);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    localparam logic [ADDR_W-1:0] BLOCK_BYTES_W  = ADDR_W'(BLOCK_BYTES);
    localparam logic [ADDR_W-1:0] HEADER_BYTES_W = ADDR_W'(8);
    localparam logic [BLK_W-1:0]  NUM_BLOCKS_W   = BLK_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0]  FREE_DEPTH_W   = CNT_W'(FREE_DEPTH);
    localparam logic [STEP_W-1:0] LAST_STEP      = STEP_W'(ADDR_W - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_BLOCKS  = 2'd1,
        ST_NULL_FREE  = 2'd2,
        ST_STORE_FULL = 2'd3
    } t_status;

    // slot size in use: low three bits dropped, zero taken as 8
    function automatic logic [SLOT_W-1:0] slot_size(input logic [SLOT_W-1:0] raw);
        logic [SLOT_W-1:0] s;
        s = raw & SLOT_W'(11'h7F8);
        slot_size = (s == '0) ? SLOT_W'(8) : s;
    endfunction

endpackage

/* rtl/core/fsp_req_if.sv */
// ---------------------------------------------------------------------------
// fsp_req_if
// Request channel: operation and address of the slot being freed.
// ---------------------------------------------------------------------------
interface fsp_req_if;
    import fsp_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, output operation, output free_address, input ready);
    modport sink   (input valid, input operation, input free_address, output ready);
endinterface

/* rtl/core/fsp_rsp_if.sv */
// ---------------------------------------------------------------------------
// fsp_rsp_if
// Response channel: allocated slot address and status code.
// ---------------------------------------------------------------------------
interface fsp_rsp_if;
    import fsp_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] slot_address;
    logic [1:0]        status;

    modport source (output valid, output slot_address, output status, input ready);
    modport sink   (input valid, input slot_address, input status, output ready);
endinterface

/* rtl/core/fixed_slot_pool_allocator_unit.sv */
// ---------------------------------------------------------------------------
// fixed_slot_pool_allocator_unit
// Fixed-size slot allocator with a LIFO free store and bump allocation.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries one item per request: operation 0 allocates a slot,
//   1 frees free_address (0 is ignored). o_rsp returns exactly one item per
//   request: the slot address (0 on a free or a failure) and a status code.
//   Config is written through i_cfg_we / i_cfg_index / i_cfg_wdata while
//   the unit is idle: index 0 slot size, index 1 region base.
// States from accept until the result enters the output register:
//   free, failed allocate, or allocate from the current block ... S_FIN
//   allocate popping a freed address ............. S_READ (store read), S_FIN
//   allocate taking a new block .................. S_DIV, S_UPD, S_FIN
//   In the new-block case the bit-serial remainder unit works out, in S_DIV,
//   the slot alignment of the block's first slot, one bit a cycle.
//   i_req.ready is high only while the sequencer is idle; one item at a time.
// Reset: counters, block pointers and config return to defaults; the free
//   store needs no clearing, its fill count marks the live entries.
// Stall: the response sits in an output register; a finished item waits
//   there, and the sequencer holds its result until that register frees.
// ---------------------------------------------------------------------------
module fixed_slot_pool_allocator_unit
    import fsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fsp_req_if.sink              i_req,
    fsp_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_DIV  = 5'b00100,
        S_UPD  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [SLOT_W-1:0] r_slot_bytes;
    logic [ADDR_W-1:0] r_region_base;
    logic [ADDR_W-1:0] r_bump;
    logic [ADDR_W-1:0] r_limit;
    logic [BLK_W-1:0]  r_blocks;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_body;
    logic [ADDR_W-1:0] r_res_addr;
    t_status           r_res_status;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    t_status           r_out_status;

    logic              w_accept;
    logic              w_out_free;
    logic [SLOT_W-1:0] w_sz;
    logic [ADDR_W-1:0] w_sz32;
    logic [ADDR_W-1:0] w_base;
    logic              w_div_start;
    logic              w_div_done;
    logic [SLOT_W-1:0] w_rem;
    logic [SLOT_W-1:0] w_pad;
    logic              w_push;
    logic              w_pop;
    logic [CNT_W-1:0]  w_count_dec;
    logic [ADDR_W-1:0] w_rdata;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_sz        = slot_size(r_slot_bytes);
    assign w_sz32      = ADDR_W'(w_sz);
    assign w_base      = r_region_base + (ADDR_W'(r_blocks) * BLOCK_BYTES_W);
    assign w_count_dec = r_count - 1'b1;

    assign w_push = w_accept && (i_req.operation == OP_FREE) && (i_req.free_address != '0)
                    && (r_count < FREE_DEPTH_W);
    assign w_pop  = w_accept && (i_req.operation == OP_ALLOC) && (r_count != '0);
    assign w_div_start = w_accept && (i_req.operation == OP_ALLOC) && (r_count == '0)
                         && (r_bump >= r_limit) && (r_blocks < NUM_BLOCKS_W);

    assign w_pad = (w_rem == '0) ? '0 : (w_sz - w_rem);

    fsp_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_base + HEADER_BYTES_W),
        .i_divisor  (w_sz),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    fsp_free_stack u_stack (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_req.free_address),
        .i_re    (w_pop),
        .i_raddr (w_count_dec[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_bytes  <= SLOT_W'(8);
            r_region_base <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLOT_BYTES:  r_slot_bytes  <= i_cfg_wdata[SLOT_W-1:0];
                CFG_REGION_BASE: r_region_base <= i_cfg_wdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_pop) begin
                        n_state = S_READ;
                    end else if (w_div_start) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_READ: n_state = S_FIN;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bump   <= '0;
            r_limit  <= '0;
            r_blocks <= '0;
            r_count  <= '0;
        end else begin
            r_state <= n_state;
            if (w_push) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop) begin
                r_count <= w_count_dec;
            end else if (w_div_start) begin
                // new block: free store emptied, limit known up front
                r_count  <= '0;
                r_blocks <= r_blocks + 1'b1;
                r_limit  <= w_base + BLOCK_BYTES_W - w_sz32 + ADDR_W'(1);
            end
            if (w_accept && (i_req.operation == OP_ALLOC) && (r_count == '0)
                && (r_bump < r_limit)) begin
                r_bump <= r_bump + w_sz32;
            end else if (r_state == S_UPD) begin
                r_bump <= r_res_addr + w_sz32;
            end
        end
    end

    // result of the item in flight
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res_addr   <= '0;
            r_res_status <= ST_OK;
            if (i_req.operation == OP_FREE) begin
                if (i_req.free_address == '0) begin
                    r_res_status <= ST_NULL_FREE;
                end else if (r_count >= FREE_DEPTH_W) begin
                    r_res_status <= ST_STORE_FULL;
                end
            end else if (r_count == '0) begin
                if (r_bump < r_limit) begin
                    r_res_addr <= r_bump;
                end else if (r_blocks >= NUM_BLOCKS_W) begin
                    r_res_status <= ST_NO_BLOCKS;
                end
            end
        end else if (r_state == S_READ) begin
            r_res_addr <= w_rdata;
        end else if ((r_state == S_DIV) && w_div_done) begin
            r_res_addr <= r_body + ADDR_W'(w_pad);
        end
        if (w_div_start) begin
            r_body <= w_base + HEADER_BYTES_W;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && w_out_free) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.slot_address = r_out_addr;
    assign o_rsp.status       = r_out_status;

    // one item at a time: the sequencer leaves idle on every accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("request accepted while busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FREE_DEPTH_W)
        else $error("free store count past depth");

    a_blocks_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blocks <= NUM_BLOCKS_W)
        else $error("more blocks taken than exist");

    a_fail_null_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_addr == '0))
        else $error("failed item carries a slot address");

endmodule

/* rtl/core/fsp_rem_unit.sv */
// ---------------------------------------------------------------------------
// fsp_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle.
// ---------------------------------------------------------------------------
module fsp_rem_unit
    import fsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_dividend,
    input  logic [SLOT_W-1:0] i_divisor,
    output logic              o_done,
    output logic [SLOT_W-1:0] o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [ADDR_W-1:0] r_quo;
    logic [SLOT_W-1:0] r_div;
    logic [SLOT_W-1:0] r_rem;
    logic [SLOT_W:0]   w_shift;
    logic [SLOT_W:0]   w_diff;

    assign w_shift = {r_rem, r_quo[ADDR_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[ADDR_W-2:0], 1'b0};
            // remainder stays below the divisor, so the top bit drops
            if (w_shift >= {1'b0, r_div}) begin
                r_rem <= w_diff[SLOT_W-1:0];
            end else begin
                r_rem <= w_shift[SLOT_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* rtl/core/fsp_free_stack.sv */
// ---------------------------------------------------------------------------
// fsp_free_stack
// Storage for freed slot addresses: one write port, one registered read.
// ---------------------------------------------------------------------------
module fsp_free_stack
    import fsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [ADDR_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [ADDR_W-1:0] o_rdata
);

    logic [ADDR_W-1:0] r_mem [FREE_DEPTH];
    logic [ADDR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
